// ===== rtl/core/bcem_pkg.sv =====
// Shared types and constants for the bounded-cycle edge marker.
// No dependencies; every other file imports this package.
package bcem_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_COMPUTE = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN    = 2'd1;

  localparam int KIND_W    = 2;
  localparam int NODE_W    = 8;
  localparam int NODES     = 256;
  localparam int IDX_W     = 12;
  localparam int COUNT_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int NCOUNT_W  = 9;
  localparam int MAXLEN_W  = 4;
  // wide enough for any layer count up to sixteen
  localparam int LCNT_W    = 5;

endpackage

// ===== rtl/core/bcem_if.sv =====
// Handshake channels of the bounded-cycle edge marker: request, result and
// configuration write. Depends on bcem_pkg.
interface bcem_in_if import bcem_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [NODE_W-1:0]   edge_tail;
  logic [NODE_W-1:0]   edge_head;
  logic [NODE_W-1:0]   root_node;
  logic [IDX_W-1:0]    edge_index;
  modport source (output valid, kind, edge_tail, edge_head, root_node, edge_index,
                  input ready);
  modport sink (input valid, kind, edge_tail, edge_head, root_node, edge_index,
                output ready);
endinterface

interface bcem_out_if import bcem_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               in_set;
  logic [COUNT_W-1:0] edges_marked;
  logic [COUNT_W-1:0] edges_loaded;
  logic               status;
  modport source (output valid, in_set, edges_marked, edges_loaded, status,
                  input ready);
  modport sink (input valid, in_set, edges_marked, edges_loaded, status,
                output ready);
endinterface

interface bcem_cfg_if import bcem_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bcem_edge_mem.sv =====
// Edge storage: endpoint memory and per-edge layer/mark memory.
// Both are synchronous, one write and one registered read per cycle. Uses bcem_pkg.
module bcem_edge_mem import bcem_pkg::*; #(
  parameter int MAX_EDGES  = 4096,
  parameter int MAX_LAYERS = 8,
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                  clk,
  input  logic                  ep_wr_en,
  input  logic [EAW-1:0]        ep_wr_addr,
  input  logic [2*NODE_W-1:0]   ep_wr_data,
  input  logic [EAW-1:0]        ep_rd_addr,
  output logic [2*NODE_W-1:0]   ep_rd_data,
  input  logic                  st_wr_en,
  input  logic [EAW-1:0]        st_wr_addr,
  input  logic [MAX_LAYERS:0]   st_wr_data,
  input  logic [EAW-1:0]        st_rd_addr,
  output logic [MAX_LAYERS:0]   st_rd_data
);

  logic [2*NODE_W-1:0] ep_mem [MAX_EDGES];
  logic [MAX_LAYERS:0] st_mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (ep_wr_en) begin
      ep_mem[ep_wr_addr] <= ep_wr_data;
    end
    ep_rd_data <= ep_mem[ep_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_wr_en) begin
      st_mem[st_wr_addr] <= st_wr_data;
    end
    st_rd_data <= st_mem[st_rd_addr];
  end

endmodule

// ===== rtl/core/bcem_node_mem.sv =====
// Per-node layer memory {return layers, reach layers}: two registered read
// ports and one write port. Uses bcem_pkg.
module bcem_node_mem import bcem_pkg::*; #(
  parameter int WORD_W = 16
) (
  input  logic              clk,
  input  logic [NODE_W-1:0] rd_a_addr,
  output logic [WORD_W-1:0] rd_a_data,
  input  logic [NODE_W-1:0] rd_b_addr,
  output logic [WORD_W-1:0] rd_b_data,
  input  logic              wr_en,
  input  logic [NODE_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== rtl/core/bounded_cycle_edge_marker_top.sv =====
// Top level of the bounded-cycle edge marker: sequencer, counters, result
// register. Depends on bcem_pkg, bcem_if, bcem_edge_mem, bcem_node_mem.
//
// Usage: requests arrive on in_ch (valid/ready), one result per request leaves
// on out_ch (valid/ready); cfg_ch writes node_count (index 0) and max_len
// (index 1) and is always ready. Request kinds: append edge, compute marks
// for a root, query one edge mark, clear the edge list.
// Append and clear pass from acceptance straight to the finishing state, a
// query through a mark-read state first. A compute first sweeps
// max(edges, node_count) entries to clear the marks, then walks every stored
// edge once per layer in a backward pass and again in a forward pass; each
// edge visit is an edge read, a node read and a node write-back.
// One request is in work at a time; the next is taken as soon as the
// sequencer is idle, even while the previous result still waits on out_ch.
// A stalled receiver holds the result register; a finished request then
// waits for it before its result is loaded.
// Reset (rst_n low, synchronous) empties the edge list, zeroes the counts
// and restores node_count to 256 and max_len to 3. Memories are not cleared.
module bounded_cycle_edge_marker_top import bcem_pkg::*; #(
  parameter int MAX_EDGES  = 4096,
  parameter int MAX_LAYERS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  bcem_in_if.sink   in_ch,
  bcem_out_if.source out_ch,
  bcem_cfg_if.sink  cfg_ch
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int LJW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int SCW = (ECW > NCOUNT_W) ? ECW : NCOUNT_W;
  localparam int ML  = MAX_LAYERS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CLR  = 8'b0000_0010,
    S_ROOT = 8'b0000_0100,
    S_ERD  = 8'b0000_1000,
    S_NRD  = 8'b0001_0000,
    S_WR   = 8'b0010_0000,
    S_QRY  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic               pass_r, pass_nxt;          // 0 backward, 1 forward
  logic [LJW-1:0]     j_r, j_nxt;
  logic [ECW-1:0]     k_r, k_nxt;
  logic [SCW-1:0]     c_r, c_nxt;
  logic [ECW-1:0]     edge_total_r, edge_total_nxt;
  logic [ECW-1:0]     mark_total_r, mark_total_nxt;
  logic [NCOUNT_W-1:0] node_count_r;
  logic [MAXLEN_W-1:0] max_len_r;
  logic [NODE_W-1:0]  root_r, root_nxt;
  logic [NODE_W-1:0]  t_r, t_nxt, h_r, h_nxt;
  logic               res_in_set_r, res_in_set_nxt;
  logic               res_status_r, res_status_nxt;
  logic               out_valid_r;
  logic               out_in_set_r, out_status_r;
  logic [COUNT_W-1:0] out_marked_r, out_loaded_r;

  // effective register values
  logic [NCOUNT_W-1:0] n_use;
  logic [LCNT_W-1:0]   lay, lay_m1;
  logic [SCW-1:0]      sweep_lim;

  // memory ports
  logic                ep_wr_en;
  logic [2*NODE_W-1:0] ep_wr_data, ep_rd_data;
  logic                st_wr_en;
  logic [EAW-1:0]      st_wr_addr, st_rd_addr;
  logic [ML:0]         st_wr_data, st_rd_data;
  logic [2*ML-1:0]     nd_a_data, nd_b_data, nd_wr_data;
  logic                nd_wr_en;
  logic [NODE_W-1:0]   nd_wr_addr;

  // write-back datapath
  logic [ML-1:0] ret_a, reach_a, ret_b, reach_b, ok_old;
  logic [ML-1:0] mask_below, mask_upto, bit_next, bit_last, bit_first;
  logic          mark_old, nodes_ok, back_hit, fwd_hit, next_in_range;

  logic in_acc, out_load, query_ok;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (node_count_r == '0) n_use = NCOUNT_W'(1);
    else if (node_count_r > NCOUNT_W'(NODES)) n_use = NCOUNT_W'(NODES);
    else n_use = node_count_r;
    if (max_len_r == '0) lay = LCNT_W'(1);
    else if ({1'b0, max_len_r} > LCNT_W'(MAX_LAYERS)) lay = LCNT_W'(MAX_LAYERS);
    else lay = {1'b0, max_len_r};
    lay_m1 = lay - LCNT_W'(1);
    sweep_lim = (SCW'(edge_total_r) > SCW'(n_use)) ? SCW'(edge_total_r) : SCW'(n_use);
  end

  assign query_ok = {{ECW{1'b0}}, in_ch.edge_index} < {{IDX_W{1'b0}}, edge_total_r};

  // layer masks for the current layer j
  always_comb begin
    for (int i = 0; i < ML; i++) begin
      mask_below[i] = (LCNT_W'(i) < LCNT_W'(j_r));
      mask_upto[i]  = (LCNT_W'(i) <= LCNT_W'(j_r));
      bit_next[i]   = (LCNT_W'(i) == LCNT_W'(j_r) + LCNT_W'(1));
      bit_last[i]   = (LCNT_W'(i) == lay_m1);
      bit_first[i]  = (i == 0);
    end
  end

  assign ret_a   = nd_a_data[2*ML-1:ML];
  assign reach_a = nd_a_data[ML-1:0];
  assign ret_b   = nd_b_data[2*ML-1:ML];
  assign reach_b = nd_b_data[ML-1:0];
  assign ok_old   = st_rd_data[ML-1:0];
  assign mark_old = st_rd_data[ML];
  assign nodes_ok = ({1'b0, t_r} < n_use) && ({1'b0, h_r} < n_use);
  assign back_hit = nodes_ok && (t_r >= root_r) && ret_a[j_r];
  assign fwd_hit  = nodes_ok && ok_old[j_r] && reach_b[j_r];
  assign next_in_range = (LCNT_W'(j_r) + LCNT_W'(1)) < lay;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    c_nxt          = c_r;
    edge_total_nxt = edge_total_r;
    mark_total_nxt = mark_total_r;
    root_nxt       = root_r;
    t_nxt          = t_r;
    h_nxt          = h_r;
    res_in_set_nxt = res_in_set_r;
    res_status_nxt = res_status_r;
    ep_wr_en   = 1'b0;
    ep_wr_data = {in_ch.edge_tail, in_ch.edge_head};
    st_wr_en   = 1'b0;
    st_wr_addr = k_r[EAW-1:0];
    st_wr_data = '0;
    nd_wr_en   = 1'b0;
    nd_wr_addr = t_r;
    nd_wr_data = '0;
    st_rd_addr = (state_r == S_IDLE) ? EAW'(in_ch.edge_index) : k_r[EAW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_in_set_nxt = 1'b0;
          res_status_nxt = 1'b0;
          case (kind_t'(in_ch.kind))
            KIND_APPEND: begin
              if (edge_total_r >= ECW'(MAX_EDGES)) begin
                res_status_nxt = 1'b1;
              end else begin
                // new entry starts unmarked
                ep_wr_en       = 1'b1;
                st_wr_en       = 1'b1;
                st_wr_addr     = edge_total_r[EAW-1:0];
                edge_total_nxt = edge_total_r + ECW'(1);
              end
              state_nxt = S_DONE;
            end
            KIND_COMPUTE: begin
              mark_total_nxt = '0;
              c_nxt          = '0;
              root_nxt       = in_ch.root_node;
              state_nxt      = S_CLR;
            end
            KIND_QUERY: begin
              res_status_nxt = !query_ok;
              state_nxt      = S_QRY;
            end
            default: begin
              edge_total_nxt = '0;
              mark_total_nxt = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        // clear one edge entry and one node entry per cycle
        st_wr_en   = (SCW'(c_r) < SCW'(edge_total_r));
        st_wr_addr = c_r[EAW-1:0];
        nd_wr_en   = (c_r < SCW'(n_use));
        nd_wr_addr = c_r[NODE_W-1:0];
        c_nxt      = c_r + SCW'(1);
        if (c_r + SCW'(1) >= sweep_lim) begin
          if ({1'b0, root_r} >= n_use) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        nd_wr_en   = 1'b1;
        nd_wr_addr = root_r;
        nd_wr_data = {bit_last, bit_first};
        pass_nxt   = 1'b0;
        j_nxt      = LJW'(lay_m1);
        k_nxt      = '0;
        state_nxt  = S_ERD;
      end
      S_ERD: begin
        if (k_r == edge_total_r) begin
          k_nxt = '0;
          if (!pass_r) begin
            if (j_r == '0) begin
              pass_nxt = 1'b1;
            end else begin
              j_nxt = j_r - LJW'(1);
            end
          end else if (LCNT_W'(j_r) == lay_m1) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt = j_r + LJW'(1);
          end
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        t_nxt     = ep_rd_data[2*NODE_W-1:NODE_W];
        h_nxt     = ep_rd_data[NODE_W-1:0];
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!pass_r) begin
          if (back_hit) begin
            nd_wr_en   = 1'b1;
            nd_wr_addr = t_r;
            nd_wr_data = {ret_b | mask_below, reach_b};
            st_wr_en   = 1'b1;
            st_wr_data = {mark_old, ok_old | mask_upto};
          end
        end else if (fwd_hit) begin
          nd_wr_en   = next_in_range;
          nd_wr_addr = h_r;
          nd_wr_data = {ret_a, reach_a | bit_next};
          if (!mark_old) begin
            st_wr_en       = 1'b1;
            st_wr_data     = {1'b1, ok_old};
            mark_total_nxt = mark_total_r + ECW'(1);
          end
        end
        k_nxt     = k_r + ECW'(1);
        state_nxt = S_ERD;
      end
      S_QRY: begin
        res_in_set_nxt = !res_status_r && st_rd_data[ML];
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pass_r       <= 1'b0;
      j_r          <= '0;
      k_r          <= '0;
      c_r          <= '0;
      edge_total_r <= '0;
      mark_total_r <= '0;
      node_count_r <= NCOUNT_W'(NODES);
      max_len_r    <= MAXLEN_W'(3);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pass_r       <= pass_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      c_r          <= c_nxt;
      edge_total_r <= edge_total_nxt;
      mark_total_r <= mark_total_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_NODE_COUNT) node_count_r <= cfg_ch.data;
        else if (cfg_ch.index == CFG_MAX_LEN) max_len_r <= cfg_ch.data[MAXLEN_W-1:0];
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    root_r       <= root_nxt;
    t_r          <= t_nxt;
    h_r          <= h_nxt;
    res_in_set_r <= res_in_set_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_in_set_r <= res_in_set_r;
      out_status_r <= res_status_r;
      out_marked_r <= COUNT_W'(mark_total_r);
      out_loaded_r <= COUNT_W'(edge_total_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.in_set       = out_in_set_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.edges_marked = out_marked_r;
  assign out_ch.edges_loaded = out_loaded_r;

  bcem_edge_mem #(
    .MAX_EDGES  (MAX_EDGES),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_edge_mem (
    .clk        (clk),
    .ep_wr_en   (ep_wr_en),
    .ep_wr_addr (edge_total_r[EAW-1:0]),
    .ep_wr_data (ep_wr_data),
    .ep_rd_addr (k_r[EAW-1:0]),
    .ep_rd_data (ep_rd_data),
    .st_wr_en   (st_wr_en),
    .st_wr_addr (st_wr_addr),
    .st_wr_data (st_wr_data),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data)
  );

  bcem_node_mem #(
    .WORD_W (2*ML)
  ) u_node_mem (
    .clk       (clk),
    .rd_a_addr (ep_rd_data[NODE_W-1:0]),
    .rd_a_data (nd_a_data),
    .rd_b_addr (ep_rd_data[2*NODE_W-1:NODE_W]),
    .rd_b_data (nd_b_data),
    .wr_en     (nd_wr_en),
    .wr_addr   (nd_wr_addr),
    .wr_data   (nd_wr_data)
  );

  // marks can never outnumber stored edges
  a_marks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    mark_total_r <= edge_total_r) else $error("mark count above edge count");

  // the backward pass never touches the mark count
  a_back_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) && !pass_r |=> $stable(mark_total_r))
    else $error("mark count changed in backward pass");

  // the edge list never grows past its capacity
  a_store_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= ECW'(MAX_EDGES)) else $error("edge count above capacity");

  // a result is only loaded from the finishing state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside finishing state");

endmodule
